// ----- rtl/aes_pkg.sv -----
// shared types, constants and tables for the aes block cipher
package aes_pkg;

  localparam int KeyWords  = 60;
  localparam int MaxRounds = 14;
  localparam int PartW     = 64;
  localparam int CfgIdxW   = 3;

  typedef enum logic [2:0] {
    CfgKeyLen = 3'd0,
    CfgKey0   = 3'd1,
    CfgKey1   = 3'd2,
    CfgKey2   = 3'd3,
    CfgKey3   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    Klen128 = 2'd0,
    Klen192 = 2'd1,
    Klen256 = 2'd2
  } klen_e;

  typedef logic [127:0] block_t;
  typedef logic [255:0][7:0] byte_tab_t;
  typedef logic [MaxRounds:0][127:0] rk_tab_t;

  // control that travels with each item
  typedef struct packed {
    logic valid;
    logic dec;
  } ctl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ p;
      p = xtime(p);
    end
    return acc;
  endfunction

  // evaluated at elaboration only
  function automatic byte_tab_t gen_tab(input logic inverse);
    byte_tab_t  t;
    logic [7:0] r;
    logic [7:0] base;
    logic [7:0] e;
    logic [7:0] s;
    logic [7:0] x;
    t = '0;
    for (int n = 0; n < 256; n++) begin
      x    = n[7:0];
      r    = 8'h01;
      base = x;
      e    = 8'd254;
      for (int k = 0; k < 8; k++) begin
        if (e[k]) r = gf_mul(r, base);
        base = gf_mul(base, base);
      end
      s = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^
          {r[3:0], r[7:4]} ^ 8'h63;
      if (inverse) t[s] = x;
      else t[x] = s;
    end
    return t;
  endfunction

  localparam byte_tab_t SBOX     = gen_tab(1'b0);
  localparam byte_tab_t INV_SBOX = gen_tab(1'b1);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

// ----- rtl/aes_key_exp.sv -----
// key schedule: one word per cycle into the round key registers
module aes_key_exp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic [1:0]        klen_i,
  input  logic [255:0]      key_i,
  output logic              busy_o,
  output aes_pkg::rk_tab_t  rk_o
);

  logic [31:0] words_q [aes_pkg::KeyWords];
  logic [7:0][31:0] win_q, win_d;
  logic [5:0] cnt_q;
  logic [2:0] phase_q;
  logic [7:0] rcon_q;
  logic       busy_q;

  logic [3:0]  nk;
  logic [5:0]  last_idx;
  logic [31:0] t, oldest, new_word;

  always_comb begin
    unique case (klen_i)
      2'd0: begin nk = 4'd4; last_idx = 6'd43; oldest = win_q[4]; end
      2'd1: begin nk = 4'd6; last_idx = 6'd51; oldest = win_q[2]; end
      default: begin nk = 4'd8; last_idx = 6'd59; oldest = win_q[0]; end
    endcase
    t = win_q[7];
    if (phase_q == 3'd0) begin
      t = aes_pkg::sub_word({win_q[7][23:0], win_q[7][31:24]}) ^ {rcon_q, 24'h0};
    end else if (nk == 4'd8 && phase_q == 3'd4) begin
      t = aes_pkg::sub_word(win_q[7]);
    end
    new_word = oldest ^ t;
    // newest key word lands in the top slot
    win_d = '0;
    for (int j = 0; j < 8; j++) begin
      unique case (klen_i)
        2'd0: if (j < 4) win_d[4 + j] = key_i[255 - 32 * j -: 32];
        2'd1: if (j < 6) win_d[2 + j] = key_i[255 - 32 * j -: 32];
        default: win_d[j] = key_i[255 - 32 * j -: 32];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      phase_q <= '0;
      rcon_q  <= 8'h01;
    end else if (go_i) begin
      busy_q  <= 1'b1;
      cnt_q   <= {2'b00, nk};
      phase_q <= '0;
      rcon_q  <= 8'h01;
    end else if (busy_q) begin
      cnt_q   <= cnt_q + 6'd1;
      phase_q <= ({1'b0, phase_q} == nk - 4'd1) ? 3'd0 : phase_q + 3'd1;
      if (phase_q == 3'd0) rcon_q <= aes_pkg::xtime(rcon_q);
      if (cnt_q == last_idx) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      win_q <= win_d;
      for (int j = 0; j < 8; j++) words_q[j] <= key_i[255 - 32 * j -: 32];
    end else if (busy_q) begin
      win_q <= {new_word, win_q[7:1]};
      words_q[cnt_q] <= new_word;
    end
  end

  always_comb begin
    for (int r = 0; r <= aes_pkg::MaxRounds; r++) begin
      rk_o[r] = {words_q[4 * r], words_q[4 * r + 1], words_q[4 * r + 2], words_q[4 * r + 3]};
    end
  end

  assign busy_o = busy_q;

endmodule

// ----- rtl/aes_round.sv -----
// one registered cipher round, encrypt or inverse
module aes_round (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  aes_pkg::ctl_t   ctl_i,
  input  aes_pkg::block_t data_i,
  input  logic [127:0]    rk_i,
  input  logic            active_i,
  input  logic            last_i,
  output aes_pkg::ctl_t   ctl_o,
  output aes_pkg::block_t data_o
);

  aes_pkg::ctl_t   ctl_q;
  aes_pkg::block_t data_q, data_d;
  aes_pkg::block_t esb, emix, dsb, dkey, dmix;
  logic [7:0] a [4];
  logic [7:0] src;

  always_comb begin
    esb = '0;
    dsb = '0;
    // byte 4c+r is row r, column c; shift and substitute together
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = data_i[127 - 8 * (4 * ((c + r) & 3) + r) -: 8];
        esb[127 - 8 * (4 * c + r) -: 8] = aes_pkg::SBOX[src];
        src = data_i[127 - 8 * (4 * ((c + 4 - r) & 3) + r) -: 8];
        dsb[127 - 8 * (4 * c + r) -: 8] = aes_pkg::INV_SBOX[src];
      end
    end
    dkey = dsb ^ rk_i;
    emix = esb;
    dmix = dkey;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) a[j] = esb[127 - 8 * (4 * c + j) -: 8];
      for (int r = 0; r < 4; r++) begin
        emix[127 - 8 * (4 * c + r) -: 8] = aes_pkg::xtime(a[r]) ^
          aes_pkg::xtime(a[(r + 1) & 3]) ^ a[(r + 1) & 3] ^ a[(r + 2) & 3] ^ a[(r + 3) & 3];
      end
      for (int j = 0; j < 4; j++) a[j] = dkey[127 - 8 * (4 * c + j) -: 8];
      for (int r = 0; r < 4; r++) begin
        dmix[127 - 8 * (4 * c + r) -: 8] =
          aes_pkg::gf_mul(a[r], 8'h0e) ^ aes_pkg::gf_mul(a[(r + 1) & 3], 8'h0b) ^
          aes_pkg::gf_mul(a[(r + 2) & 3], 8'h0d) ^ aes_pkg::gf_mul(a[(r + 3) & 3], 8'h09);
      end
    end
    if (!active_i) data_d = data_i;
    else if (ctl_i.dec) data_d = last_i ? dkey : dmix;
    else data_d = (last_i ? esb : emix) ^ rk_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign ctl_o  = ctl_q;
  assign data_o = data_q;

endmodule

// ----- rtl/aes_block_cipher.sv -----
// aes block cipher top level: config registers, key schedule and round pipeline
//
// usage:
//   configure key_length (index 0) and the four 64-bit key parts (1 to 4)
//   through cfg_we_i / cfg_idx_i / cfg_data_i; each write to index 0 to 4
//   restarts the key schedule, which raises busy while it launches and then
//   computes one word per cycle.
//   an item (command_i, block_high_i, block_low_i) is taken at each edge with
//   start high and busy low; while busy stays low, one item per cycle is
//   accepted back to back. every key size passes one initial key-add stage
//   and fourteen round stages; shorter keys pass the tail stages unchanged.
//   the result shows on result_high_o / result_low_o for one cycle with done_o.
//   the receiver cannot stall; the pipeline always advances.
//   reset clears the registers to a zero 128-bit key and then runs the key
//   schedule, so busy is high after reset until the schedule is done.
module aes_block_cipher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [aes_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [aes_pkg::PartW-1:0]   cfg_data_i,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command_i,
  input  logic [63:0]                 block_high_i,
  input  logic [63:0]                 block_low_i,
  output logic                        done_o,
  output logic [63:0]                 result_high_o,
  output logic [63:0]                 result_low_o
);

  logic [1:0]  key_len_q;
  logic [63:0] key_q [4];
  logic        go_q;
  logic        exp_busy;
  logic [1:0]  klen;
  aes_pkg::rk_tab_t rk;

  aes_pkg::ctl_t   ctl [aes_pkg::MaxRounds + 1];
  aes_pkg::block_t dat [aes_pkg::MaxRounds + 1];
  aes_pkg::ctl_t   ctl0_q;
  aes_pkg::block_t dat0_q;
  logic [127:0]    rk0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= '0;
      for (int j = 0; j < 4; j++) key_q[j] <= '0;
      go_q      <= 1'b1;
    end else begin
      go_q <= cfg_we_i && (cfg_idx_i <= aes_pkg::CfgKey3);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          aes_pkg::CfgKeyLen: key_len_q <= cfg_data_i[1:0];
          aes_pkg::CfgKey0:   key_q[0] <= cfg_data_i;
          aes_pkg::CfgKey1:   key_q[1] <= cfg_data_i;
          aes_pkg::CfgKey2:   key_q[2] <= cfg_data_i;
          aes_pkg::CfgKey3:   key_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // unused length code runs as 256
  assign klen = (key_len_q == 2'd3) ? aes_pkg::Klen256 : key_len_q;

  aes_key_exp u_key_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go_q),
    .klen_i (klen),
    .key_i  ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .busy_o (exp_busy),
    .rk_o   (rk)
  );

  assign busy = go_q | exp_busy;

  always_comb begin
    if (!command_i) rk0 = rk[0];
    else begin
      unique case (klen)
        aes_pkg::Klen128: rk0 = rk[10];
        aes_pkg::Klen192: rk0 = rk[12];
        default:          rk0 = rk[14];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else begin
      ctl0_q.valid <= start && !busy;
      ctl0_q.dec   <= command_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dat0_q <= {block_high_i, block_low_i} ^ rk0;
  end

  assign ctl[0] = ctl0_q;
  assign dat[0] = dat0_q;

  for (genvar r = 1; r <= aes_pkg::MaxRounds; r++) begin : g_round
    localparam int I10 = (r > 10) ? 0 : 10 - r;
    localparam int I12 = (r > 12) ? 0 : 12 - r;
    localparam int I14 = 14 - r;
    logic [127:0] rk_sel;
    logic         active;
    logic         last;

    always_comb begin
      unique case (klen)
        aes_pkg::Klen128: begin
          active = (r <= 10);
          last   = (r == 10);
          rk_sel = ctl[r-1].dec ? rk[I10] : rk[r];
        end
        aes_pkg::Klen192: begin
          active = (r <= 12);
          last   = (r == 12);
          rk_sel = ctl[r-1].dec ? rk[I12] : rk[r];
        end
        default: begin
          active = 1'b1;
          last   = (r == 14);
          rk_sel = ctl[r-1].dec ? rk[I14] : rk[r];
        end
      endcase
    end

    aes_round u_round (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl[r-1]),
      .data_i   (dat[r-1]),
      .rk_i     (rk_sel),
      .active_i (active),
      .last_i   (last),
      .ctl_o    (ctl[r]),
      .data_o   (dat[r])
    );
  end

  assign done_o        = ctl[aes_pkg::MaxRounds].valid;
  assign result_high_o = dat[aes_pkg::MaxRounds][127:64];
  assign result_low_o  = dat[aes_pkg::MaxRounds][63:0];

endmodule
